>>> rtl/rmvm_pkg.sv
// Shared constants, state type and control struct for the rolling mean voltage monitor.
package rmvm_pkg;

    // Default window length and converter resolution
    localparam int unsigned WINDOW_DEF      = 8;
    localparam int unsigned SAMPLE_BITS_DEF = 12;

    // Full-scale register and voltage result widths
    localparam int unsigned FS_BITS   = 16;
    localparam int unsigned VOLT_BITS = 16;

    // 3.3 V * 133 / 33 = 13.3 V full scale after the divider
    localparam logic [FS_BITS-1:0] FS_RESET = 16'd13300;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // Divider control
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

>>> rtl/rmvm_div.sv
// Bit-serial restoring divider: one quotient bit per step, dividend MSB first.
module rmvm_div #(
    parameter int unsigned DVD_W = 31,
    parameter int unsigned DVR_W = 16,
    parameter int unsigned Q_W   = 16
) (
    input  logic                 i_clk,
    input  rmvm_pkg::t_div_ctl   i_ctl,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [DVR_W-1:0]     i_divisor,
    output logic [Q_W-1:0]       o_quotient
);

    logic [DVD_W-1:0] r_dvd;
    logic [DVR_W-1:0] r_dvr;
    logic [DVR_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;

    logic [DVR_W:0]   trial;
    logic [DVR_W:0]   diff;
    logic             fits;

    // Trial subtract of the divisor from the partial remainder; no borrow means it fits
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dvr};
        fits  = ~diff[DVR_W];
    end

    // Shift registers; quotient bits shifted out of the top are always zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= i_dividend;
            r_dvr <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;

endmodule

>>> rtl/rolling_mean_voltage_monitor.sv
// Top level: sample ring, running sum, serial multiplier and two serial dividers.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  sample   | in        | i_valid / o_stall    | i_sample
//  result   | out       | o_valid / i_stall    | o_sample_count, o_mean_code, o_voltage_mv
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (full_scale_mv)
//
// Per sample: a shift-add multiply of FS_BITS steps (16 by default), then a restoring divide
// of SUM_W + FS_BITS steps (31 by default); o_stall is high until the result is registered.
// The voltage divider's one-bit-per-cycle loop runs with the mean divider alongside.
// A finished result waits in the output register while the next sample is taken in.
// Synchronous active-low reset clears sum, write slot and window flag; full scale to FS_RESET.
// The ring holds no reset; an old entry is used only once every one has been written.
module rolling_mean_voltage_monitor #(
    parameter int unsigned WINDOW      = rmvm_pkg::WINDOW_DEF,
    parameter int unsigned SAMPLE_BITS = rmvm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [$clog2(WINDOW+1)-1:0]       o_sample_count,
    output logic [SAMPLE_BITS-1:0]            o_mean_code,
    output logic [rmvm_pkg::VOLT_BITS-1:0]    o_voltage_mv,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rmvm_pkg::FS_BITS-1:0]      i_cfg_data
);

    localparam int unsigned SLOT_W = $clog2(WINDOW);
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int unsigned PROD_W = SUM_W + rmvm_pkg::FS_BITS;
    localparam int unsigned DEN_W  = CNT_W + SAMPLE_BITS;
    localparam int unsigned STEP_W = $clog2(PROD_W);

    // Sequencer and control registers
    rmvm_pkg::t_state              r_state, n_state;
    logic [STEP_W-1:0]             r_step;
    logic [SLOT_W-1:0]             r_slot;
    logic                          r_full;
    logic [SUM_W-1:0]              r_sum;
    logic [rmvm_pkg::FS_BITS-1:0]  r_fs;
    logic                          r_out_valid;

    // Payload registers
    logic [SAMPLE_BITS-1:0]        r_smp;
    logic [SAMPLE_BITS-1:0]        r_old;
    logic [CNT_W-1:0]              r_count;
    logic [PROD_W-1:0]             r_mcand;
    logic [rmvm_pkg::FS_BITS-1:0]  r_mplier;
    logic [PROD_W-1:0]             r_prod;
    logic [CNT_W-1:0]              r_out_count;
    logic [SAMPLE_BITS-1:0]        r_out_mean;
    logic [rmvm_pkg::VOLT_BITS-1:0] r_out_volt;

    // Sample ring
    logic [SAMPLE_BITS-1:0]        ring [WINDOW];

    // Control decode
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          upd;
    logic                          mul_step;
    logic                          out_wr;
    rmvm_pkg::t_div_ctl            div_ctl;

    // Datapath wires
    logic [SUM_W-1:0]              n_sum;
    logic                          slot_wrap;
    logic [DEN_W-1:0]              denom;
    logic [SAMPLE_BITS-1:0]        mean_q;
    logic [rmvm_pkg::VOLT_BITS-1:0] volt_q;

    assign in_xfer     = i_valid && !o_stall;
    assign out_xfer    = r_out_valid && !i_stall;
    assign o_cfg_ready = 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmvm_pkg::ST_IDLE: begin
                if (i_valid) n_state = rmvm_pkg::ST_UPD;
            end
            rmvm_pkg::ST_UPD: begin
                n_state = rmvm_pkg::ST_MUL;
            end
            rmvm_pkg::ST_MUL: begin
                if (r_step == STEP_W'(rmvm_pkg::FS_BITS - 1)) n_state = rmvm_pkg::ST_DLOAD;
            end
            rmvm_pkg::ST_DLOAD: begin
                n_state = rmvm_pkg::ST_DIV;
            end
            rmvm_pkg::ST_DIV: begin
                if (r_step == STEP_W'(PROD_W - 1)) n_state = rmvm_pkg::ST_OUT;
            end
            rmvm_pkg::ST_OUT: begin
                if (!r_out_valid || !i_stall) n_state = rmvm_pkg::ST_IDLE;
            end
            default: begin
                n_state = rmvm_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_stall      = 1'b1;
        upd          = 1'b0;
        mul_step     = 1'b0;
        div_ctl.load = 1'b0;
        div_ctl.step = 1'b0;
        out_wr       = 1'b0;
        case (r_state)
            rmvm_pkg::ST_IDLE:  o_stall      = 1'b0;
            rmvm_pkg::ST_UPD:   upd          = 1'b1;
            rmvm_pkg::ST_MUL:   mul_step     = 1'b1;
            rmvm_pkg::ST_DLOAD: div_ctl.load = 1'b1;
            rmvm_pkg::ST_DIV:   div_ctl.step = 1'b1;
            rmvm_pkg::ST_OUT:   out_wr       = !r_out_valid || !i_stall;
            default:            o_stall      = 1'b1;
        endcase
    end

    // Running sum: drop the oldest sample once the window is full
    always_comb begin
        n_sum     = r_sum - (r_full ? SUM_W'(r_old) : '0) + SUM_W'(r_smp);
        slot_wrap = (r_slot == SLOT_W'(WINDOW - 1));
        denom     = {r_count, {SAMPLE_BITS{1'b0}}} - DEN_W'(r_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmvm_pkg::ST_IDLE;
            r_step      <= '0;
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_fs        <= rmvm_pkg::FS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_fs <= i_cfg_data;
            if (mul_step || div_ctl.step) begin
                r_step <= (n_state != r_state) ? '0 : r_step + 1'b1;
            end
            if (upd) begin
                r_sum  <= n_sum;
                r_slot <= slot_wrap ? '0 : r_slot + 1'b1;
                if (slot_wrap) r_full <= 1'b1;
            end
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Ring: read the slot about to be overwritten, write it in the update cycle
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_smp <= i_sample;
            r_old <= ring[r_slot];
        end
        if (upd) ring[r_slot] <= r_smp;
    end

    // Sample count and shift-add multiply of sum by full scale
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_count  <= (r_full || slot_wrap) ? CNT_W'(WINDOW) : CNT_W'(r_slot) + 1'b1;
            r_mcand  <= PROD_W'(n_sum);
            r_mplier <= r_fs;
            r_prod   <= '0;
        end else if (mul_step) begin
            if (r_mplier[0]) r_prod <= r_prod + r_mcand;
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[rmvm_pkg::FS_BITS-1:1]};
        end
    end

    // Mean: sum / count, dividend widened so both dividers share one step count
    rmvm_div #(
        .DVD_W (PROD_W),
        .DVR_W (CNT_W),
        .Q_W   (SAMPLE_BITS)
    ) u_mean_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (PROD_W'(r_sum)),
        .i_divisor  (r_count),
        .o_quotient (mean_q)
    );

    // Voltage: sum * full scale / (count * code max); never above full scale
    rmvm_div #(
        .DVD_W (PROD_W),
        .DVR_W (DEN_W),
        .Q_W   (rmvm_pkg::VOLT_BITS)
    ) u_volt_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (r_prod),
        .i_divisor  (denom),
        .o_quotient (volt_q)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out_count <= r_count;
            r_out_mean  <= mean_q;
            r_out_volt  <= volt_q;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_count = r_out_count;
    assign o_mean_code    = r_out_mean;
    assign o_voltage_mv   = r_out_volt;

endmodule
